// ===== design/ptq_pkg.sv =====
`timescale 1ns / 1ps

package ptq_pkg;

  localparam int TIMER_SLOTS = 16;

  localparam int CMD_W    = 2;
  localparam int LID_W    = 16;
  localparam int PERIOD_W = 32;
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADD_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic                valid;
    logic [LID_W-1:0]    listener;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   deadline;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  // broadcast to every cell; ent carries the new entry or the remove key
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_ctrl_t;

endpackage

// ===== design/ptq_cell.sv =====
`timescale 1ns / 1ps

module ptq_cell
  import ptq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_ent,
  input  logic       left_keep,
  input  entry_t     right_ent,
  input  logic       found_in,
  output entry_t     ent,
  output logic       keep,
  output logic       found_out
);

  entry_t ent_next;
  logic   match_here;

  // entry stays in place on insert when its deadline is not later than the new one
  assign keep = ent.valid && (ent.deadline <= ctrl.ent.deadline);

  assign match_here = (ctrl.op == CELL_POP) ||
                      ((ctrl.op == CELL_REMOVE) && ent.valid &&
                       (ent.listener == ctrl.ent.listener));
  assign found_out  = found_in || match_here;

  always_comb begin
    ent_next = ent;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (left_keep) ent_next = ctrl.ent;
          else           ent_next = left_ent;
        end
      end
      CELL_REMOVE, CELL_POP: begin
        if (found_out) ent_next = right_ent;
      end
      default: ent_next = ent;
    endcase
  end

  // only the valid bit is reset, the payload follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.listener <= ent_next.listener;
    ent.period   <= ent_next.period;
    ent.deadline <= ent_next.deadline;
  end

endmodule

// ===== design/periodic_timer_queue.sv =====
`timescale 1ns / 1ps

// channel | dir | tvalid/tready | tuser          | tdata (lsb first)
// s_*     | in  | s_tvalid/rdy  | command[1:0]   | listener[15:0], amount[47:16]
// m_*     | out | m_tvalid/rdy  | status[2:0]    | fired_listener[15:0], lateness[47:16]
//
// the sequencer runs an add through arm, insert and done, a remove through remove and
// done, a tick through arm, fire and done, or on a fire through arm, fire, rearm, insert
// and done, and the unused command straight to done; it has one add/compare unit for
// time and one broadcast step (insert, remove or pop) applied to the whole row of cells
// rst is synchronous, clears the time counter, the valid bits and the sequencer
// a new beat is taken once the sequencer is back in idle, even while the previous
// result still sits in the output register waiting on m_tready

module periodic_timer_queue
  import ptq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CMD_W-1:0]    s_tuser,   // command
  input  logic [47:0]         s_tdata,   // listener, amount
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [STATUS_W-1:0] m_tuser,   // status
  output logic [47:0]         m_tdata    // fired_listener, lateness
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ARM    = 7'b0000010,
    S_FIRE   = 7'b0000100,
    S_REARM  = 7'b0001000,
    S_INSERT = 7'b0010000,
    S_REMOVE = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [TIME_W-1:0]   now_time;
  logic [CMD_W-1:0]    pend_cmd;
  logic [LID_W-1:0]    pend_listener;
  logic [PERIOD_W-1:0] pend_period;
  logic [TIME_W-1:0]   pend_deadline;
  logic [STATUS_W-1:0] res_status;
  logic [LID_W-1:0]    res_listener;
  logic [PERIOD_W-1:0] res_late;

  // cell row wiring
  cell_ctrl_t             ctrl;
  entry_t                 cell_ent  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] cell_keep;
  logic [TIMER_SLOTS-1:0] cell_found;
  logic [TIMER_SLOTS-1:0] vmask;

  logic                full;
  logic                fire;
  logic [TIME_W-1:0]   arm_sum;
  logic [TIME_W-1:0]   late_diff;
  logic [PERIOD_W-1:0] late_sat;
  logic                out_free;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [PERIOD_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W - PERIOD_W + 1){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign full    = vmask[TIMER_SLOTS-1];
  assign arm_sum = sat_add(now_time, pend_period);

  // head of the sorted row is the earliest deadline
  assign fire      = cell_ent[0].valid && (now_time >= cell_ent[0].deadline);
  assign late_diff = now_time - cell_ent[0].deadline;
  assign late_sat  = (|late_diff[TIME_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                      : late_diff[PERIOD_W-1:0];

  always_comb begin
    ctrl.ent = '{valid: 1'b1, listener: pend_listener, period: pend_period,
                 deadline: pend_deadline};
    case (state)
      S_INSERT: ctrl.op = full ? CELL_HOLD : CELL_INSERT;
      S_REMOVE: ctrl.op = CELL_REMOVE;
      S_FIRE:   ctrl.op = fire ? CELL_POP : CELL_HOLD;
      default:  ctrl.op = CELL_HOLD;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
      entry_t left_ent;
      entry_t right_ent;
      logic   left_keep;
      logic   found_in;

      if (gi == 0) begin : g_head
        // nothing ahead of the head: a new entry lands here unless the head stays
        assign left_ent  = '0;
        assign left_keep = 1'b1;
        assign found_in  = 1'b0;
      end else begin : g_body
        assign left_ent  = cell_ent[gi-1];
        assign left_keep = cell_keep[gi-1];
        assign found_in  = cell_found[gi-1];
      end

      if (gi == TIMER_SLOTS - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_mid
        assign right_ent = cell_ent[gi+1];
      end

      ptq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left_ent  (left_ent),
        .left_keep (left_keep),
        .right_ent (right_ent),
        .found_in  (found_in),
        .ent       (cell_ent[gi]),
        .keep      (cell_keep[gi]),
        .found_out (cell_found[gi])
      );

      assign vmask[gi] = cell_ent[gi].valid;
    end
  endgenerate

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      now_time <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            case (s_tuser)
              CMD_TICK, CMD_ADD: state <= S_ARM;
              CMD_REMOVE:        state <= S_REMOVE;
              default:           state <= S_DONE;
            endcase
          end
        end
        S_ARM: begin
          // tick advances time, add computes the new deadline
          if (pend_cmd == CMD_TICK) begin
            now_time <= arm_sum;
            state    <= S_FIRE;
          end else begin
            state <= S_INSERT;
          end
        end
        S_FIRE:   state <= fire ? S_REARM : S_DONE;
        S_REARM:  state <= S_INSERT;
        S_INSERT: state <= S_DONE;
        S_REMOVE: state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register valid: loaded from done, dropped once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // pending item and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          pend_cmd      <= s_tuser;
          pend_listener <= s_tdata[LID_W-1:0];
          pend_period   <= s_tdata[LID_W +: PERIOD_W];
          res_status    <= ST_NOTHING;
          res_listener  <= '0;
          res_late      <= '0;
        end
      end
      S_ARM: begin
        if (pend_cmd != CMD_TICK) pend_deadline <= arm_sum;
      end
      S_FIRE: begin
        if (fire) begin
          pend_listener <= cell_ent[0].listener;
          pend_period   <= cell_ent[0].period;
          // listener zero is re-armed without a report
          if (cell_ent[0].listener != '0) begin
            res_status   <= ST_FIRED;
            res_listener <= cell_ent[0].listener;
            res_late     <= late_sat;
          end
        end
      end
      S_REARM: pend_deadline <= arm_sum;
      S_INSERT: begin
        if (pend_cmd == CMD_ADD) res_status <= full ? ST_ADD_FULL : ST_ADDED;
      end
      S_REMOVE: begin
        res_status <= cell_found[TIMER_SLOTS-1] ? ST_REMOVED : ST_NOT_FOUND;
      end
      S_DONE: begin
        if (out_free) begin
          m_tuser <= res_status;
          m_tdata <= {res_late, res_listener};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // valid entries always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vmask + {{(TIMER_SLOTS-1){1'b0}}, 1'b1}) & vmask) == '0)
    else $error("valid entries do not form a prefix");

  // an insert into a row with room grows it by exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) && !full |=>
      $countones(vmask) == $past($countones(vmask)) + 1)
    else $error("insert did not add one entry");

  // a firing pop removes exactly one entry
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIRE) && fire |=>
      $countones(vmask) + 1 == $past($countones(vmask)))
    else $error("pop did not remove one entry");

  // only a fired result carries listener and lateness
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_FIRED) |-> m_tdata == '0)
    else $error("unreported fields are not zero");

  // deadlines stay sorted along the row
  generate
    for (gi = 0; gi < TIMER_SLOTS - 1; gi++) begin : g_order_chk
      a_sorted: assert property (@(posedge clk) disable iff (rst)
        cell_ent[gi+1].valid |-> cell_ent[gi].deadline <= cell_ent[gi+1].deadline)
        else $error("row out of deadline order");
    end
  endgenerate
`endif

endmodule

// ===== tb/tb_periodic_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_periodic_timer_queue;
  import ptq_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam int                RANDOM_BEATS = 1820;
  localparam int                HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LID_W-1:0]    fired;
    logic [PERIOD_W-1:0] late;
  } timer_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LID_W-1:0]    lid;
    logic [PERIOD_W-1:0] amt;
    logic                typed;
    timer_result_t       want;
  } plan_row_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [CMD_W-1:0]    s_tuser  = '0;   // command
  logic [47:0]         s_tdata  = '0;   // listener[15:0], amount[47:16]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [STATUS_W-1:0] m_tuser;         // status
  logic [47:0]         m_tdata;         // fired_listener[15:0], lateness[47:16]

  periodic_timer_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // timer table mirror, kept sorted by due time
  logic [TIME_W-1:0]   clock_now = '0;
  logic [LID_W-1:0]    slot_lid    [TIMER_SLOTS];
  logic [PERIOD_W-1:0] slot_period [TIMER_SLOTS];
  logic [TIME_W-1:0]   slot_due    [TIMER_SLOTS];
  int                  slots_used = 0;

  timer_result_t pending_results [$];
  plan_row_t     directed_plan [$];

  int errors       = 0;
  int beats_sent   = 0;
  int results_seen = 0;
  int status_seen [8];
  bit idle_on      = 1'b1;
  bit hold_req     = 1'b0;

  function automatic logic [TIME_W-1:0] time_plus(input logic [TIME_W-1:0] t,
                                                   input logic [PERIOD_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W - PERIOD_W + 1){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // new entry lands after every entry with an equal due time
  function automatic bit arm_timer(input logic [LID_W-1:0] lid,
                                   input logic [PERIOD_W-1:0] period);
    int                pos;
    logic [TIME_W-1:0] due;
    if (slots_used >= TIMER_SLOTS) return 1'b0;
    due = time_plus(clock_now, period);
    pos = 0;
    while (pos < slots_used && slot_due[pos] <= due) pos++;
    for (int i = slots_used; i > pos; i--) begin
      slot_lid[i]    = slot_lid[i-1];
      slot_period[i] = slot_period[i-1];
      slot_due[i]    = slot_due[i-1];
    end
    slot_lid[pos]    = lid;
    slot_period[pos] = period;
    slot_due[pos]    = due;
    slots_used++;
    return 1'b1;
  endfunction

  function automatic void drop_timer(input int pos);
    for (int i = pos; i + 1 < slots_used; i++) begin
      slot_lid[i]    = slot_lid[i+1];
      slot_period[i] = slot_period[i+1];
      slot_due[i]    = slot_due[i+1];
    end
    slots_used--;
  endfunction

  function automatic timer_result_t predict_timer_result(input logic [CMD_W-1:0] cmd,
                                                         input logic [LID_W-1:0] lid,
                                                         input logic [PERIOD_W-1:0] amt);
    timer_result_t       r;
    logic [LID_W-1:0]    fl;
    logic [PERIOD_W-1:0] per;
    logic [TIME_W-1:0]   lag;
    r = '0;
    r.status = ST_NOTHING;
    case (cmd)
      CMD_TICK: begin
        clock_now = time_plus(clock_now, amt);
        if (slots_used > 0 && clock_now >= slot_due[0]) begin
          fl  = slot_lid[0];
          per = slot_period[0];
          lag = clock_now - slot_due[0];
          drop_timer(0);
          void'(arm_timer(fl, per));
          // listener zero is re-armed without a report
          if (fl != '0) begin
            r.status = ST_FIRED;
            r.fired  = fl;
            r.late   = (lag > 48'h0000_FFFF_FFFF) ? '1 : lag[PERIOD_W-1:0];
          end
        end
      end
      CMD_ADD: r.status = arm_timer(lid, amt) ? ST_ADDED : ST_ADD_FULL;
      CMD_REMOVE: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < slots_used; i++) begin
          if (r.status == ST_NOT_FOUND && slot_lid[i] == lid) begin
            drop_timer(i);
            r.status = ST_REMOVED;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [LID_W-1:0] pick_listener();
    logic [LID_W-1:0] pool [8];
    pool = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
             16'h00FF, 16'h8000, 16'hFFFF, 16'h1234};
    if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 7)];
    return LID_W'($urandom);
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    // a few fixed periods so that due times collide
    if (r < 50) begin
      case ($urandom_range(0, 2))
        0:       return 32'h0001_0000;
        1:       return 32'h0000_8000;
        default: return 32'h0004_0000;
      endcase
    end
    if (r < 80) return $urandom_range(1, 32'h0008_0000);
    return $urandom;
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    if (r < 60) return $urandom_range(0, 32'h0004_0000);
    if (r < 80) return $urandom_range(0, 32'h0020_0000);
    return $urandom;
  endfunction

  // mode 0 balanced, 1 add heavy, 2 remove heavy, 3 tick heavy
  function automatic logic [CMD_W-1:0] pick_command(input int mode);
    int r;
    int add_w;
    int rem_w;
    int unused_w;
    r = $urandom_range(0, 99);
    case (mode)
      1:       begin add_w = 70; rem_w = 5;  unused_w = 3; end
      2:       begin add_w = 10; rem_w = 55; unused_w = 3; end
      3:       begin add_w = 15; rem_w = 10; unused_w = 2; end
      default: begin add_w = 35; rem_w = 20; unused_w = 5; end
    endcase
    if (r < add_w) return CMD_ADD;
    if (r < add_w + rem_w) return CMD_REMOVE;
    if (r < add_w + rem_w + unused_w) return CMD_UNUSED;
    return CMD_TICK;
  endfunction

  task automatic plan_row(input logic [CMD_W-1:0] cmd, input logic [LID_W-1:0] lid,
                          input logic [PERIOD_W-1:0] amt, input logic typed,
                          input logic [STATUS_W-1:0] st, input logic [LID_W-1:0] fl,
                          input logic [PERIOD_W-1:0] late);
    plan_row_t row;
    row.cmd         = cmd;
    row.lid         = lid;
    row.amt         = amt;
    row.typed       = typed;
    row.want.status = st;
    row.want.fired  = fl;
    row.want.late   = late;
    directed_plan = {directed_plan, row};
  endtask

  // offer one beat; the expectation is recorded at the accepting edge
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [LID_W-1:0] lid,
                           input logic [PERIOD_W-1:0] amt, input logic typed,
                           input timer_result_t want);
    int            gap;
    timer_result_t predicted;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {amt, lid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_timer_result(cmd, lid, amt);
    pending_results = {pending_results, (typed ? want : predicted)};
    beats_sent++;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin : result_sink
    timer_result_t got;
    timer_result_t want;
    int            stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.fired  = m_tdata[15:0];
        got.late   = m_tdata[47:16];
        results_seen++;
        status_seen[got.status]++;
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation waiting: status %0d", got.status);
          errors++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("fired_listener", 32'(want.fired), 32'(got.fired));
          check_field("lateness", want.late, got.late);
        end
      end
      // long back-pressure so the output register fills and the input stalls
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (!idle_on) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    timer_result_t  none;
    plan_row_t      row;
    int             mode;
    logic [CMD_W-1:0] cmd;
    logic [LID_W-1:0] lid;

    none = '0;

    // directed part: empty table, odd command, extremes, zero listener,
    // lateness saturation, equal due times, full table
    plan_row(CMD_TICK,   16'h0000, 32'h0000_0000, 1'b1, ST_NOTHING,   16'h0000, 32'h0);
    plan_row(CMD_REMOVE, 16'h1234, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 16'h0000, 32'h0);
    plan_row(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_NOTHING,   16'h0000, 32'h0);
    plan_row(CMD_ADD,    16'hFFFF, 32'h0000_0000, 1'b1, ST_ADDED,     16'h0000, 32'h0);
    plan_row(CMD_TICK,   16'h0000, 32'h0000_0000, 1'b1, ST_FIRED,     16'hFFFF, 32'h0);
    plan_row(CMD_REMOVE, 16'hFFFF, 32'h0000_0000, 1'b1, ST_REMOVED,   16'h0000, 32'h0);
    plan_row(CMD_ADD,    16'h0000, 32'h0000_0001, 1'b1, ST_ADDED,     16'h0000, 32'h0);
    plan_row(CMD_TICK,   16'h0000, 32'h0000_0001, 1'b1, ST_NOTHING,   16'h0000, 32'h0);
    plan_row(CMD_ADD,    16'hA5A5, 32'h0000_0000, 1'b1, ST_ADDED,     16'h0000, 32'h0);
    plan_row(CMD_ADD,    16'h5A5A, 32'h0000_0000, 1'b1, ST_ADDED,     16'h0000, 32'h0);
    plan_row(CMD_TICK,   16'h0000, 32'hFFFF_FFFF, 1'b1, ST_FIRED,     16'hA5A5,
             32'hFFFF_FFFF);
    plan_row(CMD_TICK,   16'h0000, 32'hFFFF_FFFF, 1'b1, ST_FIRED,     16'h5A5A,
             32'hFFFF_FFFF);
    // three entries left; fill the rest with repeated listeners and periods
    for (int i = 0; i < TIMER_SLOTS - 3; i++) begin
      plan_row(CMD_ADD, LID_W'((i % 5) + 1),
               (i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'h0001_0000 : 32'hFFFF_FFFF,
               1'b1, ST_ADDED, 16'h0000, 32'h0);
    end
    plan_row(CMD_ADD,    16'h7777, 32'h0000_0010, 1'b1, ST_ADD_FULL,  16'h0000, 32'h0);
    plan_row(CMD_TICK,   16'h0000, 32'h0000_0000, 1'b0, ST_NOTHING,   16'h0000, 32'h0);
    plan_row(CMD_REMOVE, 16'h0003, 32'h0000_0000, 1'b0, ST_NOTHING,   16'h0000, 32'h0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[k]) begin
      row = directed_plan[k];
      send_beat(row.cmd, row.lid, row.amt, row.typed, row.want);
    end

    // random part: the mix drifts between filling, draining and ticking
    mode = 0;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 150 == 0) begin
        mode    = $urandom_range(0, 3);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (i == 600 || i == 1300) hold_req = 1'b1;
      cmd = pick_command(mode);
      lid = pick_listener();
      if (cmd == CMD_REMOVE && slots_used > 0 && $urandom_range(0, 1) == 1)
        lid = slot_lid[$urandom_range(0, slots_used - 1)];
      send_beat(cmd, lid, (cmd == CMD_TICK) ? pick_step() : pick_period(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d beats offered and taken, %0d results checked",
             beats_sent, results_seen);
    $display("run: fired %0d, added %0d, dropped on full %0d, removed %0d, not found %0d",
             status_seen[ST_FIRED], status_seen[ST_ADDED], status_seen[ST_ADD_FULL],
             status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
